[sv/crsd_pkg.sv]
// Shared types, codes and GF(2^8) arithmetic for the Cauchy RS erasure decoder.
// No dependencies; used by every other file of the block but crsd_ram.
package crsd_pkg;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_DECODE = 2'd1,
        OP_READ   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        STS_OK       = 3'd0,
        STS_NONE     = 3'd1,
        STS_TOO_MANY = 3'd2,
        STS_SINGULAR = 3'd3,
        STS_BADCFG   = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        REG_SOURCE_UNITS = 2'd0,
        REG_PARITY_UNITS = 2'd1,
        REG_UNIT_BYTES   = 2'd2,
        REG_FIELD_POLY   = 2'd3
    } reg_idx_t;

    typedef enum logic [5:0] {
        ST_IDLE, ST_RD, ST_SEL, ST_CC_GO, ST_CC_WT,
        ST_BL_RD, ST_BL_U, ST_BL_EL, ST_BL_WT,
        ST_PV_RD, ST_PV_CK, ST_SW_A, ST_SW_B, ST_SW_C, ST_SW_D,
        ST_NM_RD, ST_NM_GO, ST_NM_WT, ST_NM_A, ST_NM_B,
        ST_EL_RD, ST_EL_CK, ST_EL_A, ST_EL_B, ST_EL_C,
        ST_RB_E, ST_RB_CLR, ST_RB_CRD, ST_RB_CCK, ST_RB_A, ST_RB_B, ST_RB_C
    } state_t;

    // shift-and-add product, reduced by the programmable polynomial
    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b,
                                          input logic [7:0] poly);
        logic [7:0] acc;
        logic [7:0] aa;
        logic       carry;
        acc = 8'd0;
        aa  = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) acc = acc ^ aa;
            carry = aa[7];
            aa    = {aa[6:0], 1'b0};
            if (carry) aa = aa ^ poly;
        end
        return acc;
    endfunction

endpackage

[sv/crsd_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module crsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

[sv/crsd_gf_inv.sv]
// Iterative GF(2^8) inverse: tries one candidate per cycle, smallest first.
// Depends on crsd_pkg (gf_mul). Result 0 means no inverse exists.
module crsd_gf_inv (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       start,
    input  logic [7:0] x,
    input  logic [7:0] poly,
    output logic       done,
    output logic [7:0] inv
);
    logic       busy_reg, busy_next;
    logic       done_reg, done_next;
    logic [7:0] b_reg, b_next;
    logic [7:0] x_reg, x_next;
    logic [7:0] res_reg, res_next;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        b_next    = b_reg;
        x_next    = x_reg;
        res_next  = res_reg;
        if (start) begin
            busy_next = 1'b1;
            b_next    = 8'd1;
            x_next    = x;
        end else if (busy_reg) begin
            if (crsd_pkg::gf_mul(x_reg, b_reg, poly) == 8'd1) begin
                res_next  = b_reg;
                done_next = 1'b1;
                busy_next = 1'b0;
            end else if (b_reg == 8'hFF) begin
                res_next  = 8'd0;
                done_next = 1'b1;
                busy_next = 1'b0;
            end else begin
                b_next = b_reg + 8'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        b_reg   <= b_next;
        x_reg   <= x_next;
        res_reg <= res_next;
    end

    assign done = done_reg;
    assign inv  = res_reg;
endmodule

[sv/cauchy_rs_erasure_decoder_unit.sv]
// Cauchy Reed-Solomon erasure decoder over GF(2^8), top level.
// Depends on crsd_pkg, crsd_ram and crsd_gf_inv.
//
// Usage: a load word writes one byte of the frame store, a read word returns
// one byte; both take one word at a time, and a read waits on the registered
// read data of the frame RAM. A decode word picks the first k survivors,
// builds their generator rows, inverts the k x k matrix by Gauss-Jordan and
// rebuilds every erased source unit. Decode holds s_ready low throughout: it
// qualifies the code elements (one trial per cycle in the inverse search
// unit), builds the rows, runs the elimination (one read-modify-write of the
// matrix RAMs per element) and rebuilds each erased unit, bounded by the
// single read port of the frame RAM. Early-exit statuses skip these steps.
// The result sits in an output register; a new word is taken in the cycle
// the previous result is taken. Registers (APB, 4 bytes apart):
// source_units, parity_units, unit_bytes, field_poly; write them only while
// the block is idle.
module cauchy_rs_erasure_decoder_unit #(
    parameter int MAX_UNITS      = 64,
    parameter int MAX_UNIT_BYTES = 2048
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input words
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [5:0]  s_unit_index,
    input  logic [10:0] s_byte_offset,
    input  logic [7:0]  s_byte_value,
    input  logic [63:0] s_present_mask,
    // result words
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_read_value,
    output logic [2:0]  m_status,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int UW = $clog2(MAX_UNITS);                         // unit index bits
    localparam int BW = (MAX_UNIT_BYTES > 1) ? $clog2(MAX_UNIT_BYTES) : 1;
    localparam int CW = UW + 1;                                    // loop counters
    localparam int FAW = UW + BW;
    localparam int MAW = 2 * UW;

    function automatic logic [FAW-1:0] faddr(input logic [6:0] unit, input logic [16:0] off);
        return {unit[UW-1:0], off[BW-1:0]};
    endfunction

    function automatic logic [MAW-1:0] maddr(input logic [6:0] row, input logic [6:0] col);
        return {row[UW-1:0], col[UW-1:0]};
    endfunction

    // ---------------- configuration registers ----------------
    logic [5:0]  k_reg, m_reg;
    logic [11:0] ub_reg;
    logic [7:0]  poly_reg;
    logic        cfg_we;

    assign cfg_we = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg    <= 6'd4;
            m_reg    <= 6'd2;
            ub_reg   <= 12'd1024;
            poly_reg <= 8'd29;
        end else if (cfg_we) begin
            case (crsd_pkg::reg_idx_t'(paddr[3:2]))
                crsd_pkg::REG_SOURCE_UNITS: k_reg    <= pwdata[5:0];
                crsd_pkg::REG_PARITY_UNITS: m_reg    <= pwdata[5:0];
                crsd_pkg::REG_UNIT_BYTES:   ub_reg   <= pwdata[11:0];
                crsd_pkg::REG_FIELD_POLY:   poly_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (crsd_pkg::reg_idx_t'(paddr[3:2]))
            crsd_pkg::REG_SOURCE_UNITS: prdata = {26'd0, k_reg};
            crsd_pkg::REG_PARITY_UNITS: prdata = {26'd0, m_reg};
            crsd_pkg::REG_UNIT_BYTES:   prdata = {20'd0, ub_reg};
            crsd_pkg::REG_FIELD_POLY:   prdata = {24'd0, poly_reg};
            default:                    prdata = 32'd0;
        endcase
    end

    // ---------------- state ----------------
    crsd_pkg::state_t state_reg, state_next;
    logic          m_valid_reg, m_valid_next;
    logic [7:0]    rv_reg, rv_next;
    logic [2:0]    st_reg, st_next;
    logic [63:0]   mask_reg, mask_next;
    logic          rdok_reg, rdok_next;
    logic [CW-1:0] u_reg, u_next, cnt_reg, cnt_next;
    logic [CW-1:0] r_reg, r_next, j_reg, j_next;
    logic [CW-1:0] col_reg, col_next, piv_reg, piv_next, e_reg, e_next;
    logic [11:0]   t_reg, t_next;
    logic [UW-1:0] usel_reg, usel_next, src_reg, src_next;
    logic [7:0]    f_reg, f_next, ip_reg, ip_next, c_reg, c_next;
    logic [7:0]    tmpw_reg, tmpw_next, tmpi_reg, tmpi_next, srcb_reg, srcb_next;

    // memory ports
    logic           f_we;  logic [FAW-1:0] f_waddr, f_raddr; logic [7:0] f_wdata, f_rdata;
    logic           w_we;  logic [MAW-1:0] w_waddr, w_raddr; logic [7:0] w_wdata, w_rdata;
    logic           i_we;  logic [MAW-1:0] i_waddr, i_raddr; logic [7:0] i_wdata, i_rdata;
    logic           c_we;  logic [UW-1:0]  c_waddr, c_raddr; logic [UW-1:0] c_wdata, c_rdata;

    // inverse search unit
    logic       inv_start, inv_done;
    logic [7:0] inv_x, inv_res;

    // ---------------- decode helpers ----------------
    logic [6:0]    k7, m7, total7, r7, j7, col7, piv7, e7, usel7, src7;
    logic [CW-1:0] kc, mc, totc;
    logic          acc, in_ok, badcfg, erased;
    logic          j_last, r_last, rm_last, col_last, t_last;
    logic [7:0]    cc_x, bl_x;

    assign k7     = {1'b0, k_reg};
    assign m7     = {1'b0, m_reg};
    assign total7 = k7 + m7;
    assign kc     = k7[CW-1:0];
    assign mc     = m7[CW-1:0];
    assign totc   = total7[CW-1:0];
    assign r7     = 7'(r_reg);
    assign j7     = 7'(j_reg);
    assign col7   = 7'(col_reg);
    assign piv7   = 7'(piv_reg);
    assign e7     = 7'(e_reg);
    assign usel7  = 7'(usel_reg);
    assign src7   = 7'(src_reg);

    assign s_ready = (state_reg == crsd_pkg::ST_IDLE) && (!m_valid_reg || m_ready);
    assign acc     = s_valid && s_ready;
    assign in_ok   = (32'(s_unit_index) < 32'(MAX_UNITS)) &&
                     (32'(s_byte_offset) < 32'(MAX_UNIT_BYTES));
    assign badcfg  = (k_reg == 6'd0) || (m_reg == 6'd0) || (32'(total7) > 32'(MAX_UNITS)) ||
                     (ub_reg == 12'd0) || (32'(ub_reg) > 32'(MAX_UNIT_BYTES));
    // an erased source unit among the first k
    assign erased  = |(~mask_reg & ((64'd1 << k_reg) - 64'd1));

    assign j_last   = (j_reg == kc - CW'(1));
    assign r_last   = (r_reg == kc - CW'(1));
    assign rm_last  = (r_reg == mc - CW'(1));
    assign col_last = (col_reg == kc - CW'(1));
    assign t_last   = (t_reg == ub_reg - 12'd1);

    // Cauchy element: inverse of row xor (m + column)
    assign cc_x = 8'(r7) ^ (8'(m7) + 8'(j7));
    assign bl_x = (8'(usel7) - 8'(k7)) ^ (8'(m7) + 8'(j7));

    // ---------------- next state ----------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            crsd_pkg::ST_IDLE: begin
                if (acc && crsd_pkg::op_t'(s_operation) == crsd_pkg::OP_READ)
                    state_next = crsd_pkg::ST_RD;
                else if (acc && crsd_pkg::op_t'(s_operation) == crsd_pkg::OP_DECODE && !badcfg)
                    state_next = crsd_pkg::ST_SEL;
            end
            crsd_pkg::ST_RD: state_next = crsd_pkg::ST_IDLE;
            crsd_pkg::ST_SEL: begin
                if (cnt_reg == kc || u_reg == totc)
                    state_next = (cnt_reg == kc && erased) ? crsd_pkg::ST_CC_GO
                                                           : crsd_pkg::ST_IDLE;
            end
            crsd_pkg::ST_CC_GO: state_next = crsd_pkg::ST_CC_WT;
            crsd_pkg::ST_CC_WT: begin
                if (inv_done) begin
                    if (inv_res == 8'd0)          state_next = crsd_pkg::ST_IDLE;
                    else if (j_last && rm_last)   state_next = crsd_pkg::ST_BL_RD;
                    else                          state_next = crsd_pkg::ST_CC_GO;
                end
            end
            crsd_pkg::ST_BL_RD: state_next = crsd_pkg::ST_BL_U;
            crsd_pkg::ST_BL_U:  state_next = crsd_pkg::ST_BL_EL;
            crsd_pkg::ST_BL_EL, crsd_pkg::ST_BL_WT: begin
                if (state_reg == crsd_pkg::ST_BL_EL && usel7 >= k7)
                    state_next = crsd_pkg::ST_BL_WT;
                else if (state_reg == crsd_pkg::ST_BL_EL || inv_done) begin
                    if (!j_last)      state_next = crsd_pkg::ST_BL_EL;
                    else if (!r_last) state_next = crsd_pkg::ST_BL_RD;
                    else              state_next = crsd_pkg::ST_PV_RD;
                end
            end
            crsd_pkg::ST_PV_RD: state_next = crsd_pkg::ST_PV_CK;
            crsd_pkg::ST_PV_CK: begin
                if (w_rdata != 8'd0)
                    state_next = (r_reg != col_reg) ? crsd_pkg::ST_SW_A : crsd_pkg::ST_NM_RD;
                else if (r_last)
                    state_next = crsd_pkg::ST_IDLE;
                else
                    state_next = crsd_pkg::ST_PV_RD;
            end
            crsd_pkg::ST_SW_A: state_next = crsd_pkg::ST_SW_B;
            crsd_pkg::ST_SW_B: state_next = crsd_pkg::ST_SW_C;
            crsd_pkg::ST_SW_C: state_next = crsd_pkg::ST_SW_D;
            crsd_pkg::ST_SW_D: state_next = j_last ? crsd_pkg::ST_NM_RD : crsd_pkg::ST_SW_A;
            crsd_pkg::ST_NM_RD: state_next = crsd_pkg::ST_NM_GO;
            crsd_pkg::ST_NM_GO: state_next = crsd_pkg::ST_NM_WT;
            crsd_pkg::ST_NM_WT: begin
                if (inv_done)
                    state_next = (inv_res == 8'd0) ? crsd_pkg::ST_IDLE : crsd_pkg::ST_NM_A;
            end
            crsd_pkg::ST_NM_A: state_next = crsd_pkg::ST_NM_B;
            crsd_pkg::ST_NM_B: state_next = j_last ? crsd_pkg::ST_EL_RD : crsd_pkg::ST_NM_A;
            crsd_pkg::ST_EL_RD, crsd_pkg::ST_EL_CK, crsd_pkg::ST_EL_C: begin
                if (state_reg == crsd_pkg::ST_EL_RD && r_reg != col_reg)
                    state_next = crsd_pkg::ST_EL_CK;
                else if (state_reg == crsd_pkg::ST_EL_CK && w_rdata != 8'd0)
                    state_next = crsd_pkg::ST_EL_A;
                else if (state_reg == crsd_pkg::ST_EL_C && !j_last)
                    state_next = crsd_pkg::ST_EL_A;
                else if (!r_last)
                    state_next = crsd_pkg::ST_EL_RD;
                else
                    state_next = col_last ? crsd_pkg::ST_RB_E : crsd_pkg::ST_PV_RD;
            end
            crsd_pkg::ST_EL_A: state_next = crsd_pkg::ST_EL_B;
            crsd_pkg::ST_EL_B: state_next = crsd_pkg::ST_EL_C;
            crsd_pkg::ST_RB_E: begin
                if (e_reg == kc)                       state_next = crsd_pkg::ST_IDLE;
                else if (!mask_reg[e_reg[UW-1:0]])     state_next = crsd_pkg::ST_RB_CLR;
            end
            crsd_pkg::ST_RB_CLR: if (t_last) state_next = crsd_pkg::ST_RB_CRD;
            crsd_pkg::ST_RB_CRD: state_next = crsd_pkg::ST_RB_CCK;
            crsd_pkg::ST_RB_CCK, crsd_pkg::ST_RB_C: begin
                if (state_reg == crsd_pkg::ST_RB_CCK && i_rdata != 8'd0)
                    state_next = crsd_pkg::ST_RB_A;
                else if (state_reg == crsd_pkg::ST_RB_C && !t_last)
                    state_next = crsd_pkg::ST_RB_A;
                else
                    state_next = r_last ? crsd_pkg::ST_RB_E : crsd_pkg::ST_RB_CRD;
            end
            crsd_pkg::ST_RB_A: state_next = crsd_pkg::ST_RB_B;
            crsd_pkg::ST_RB_B: state_next = crsd_pkg::ST_RB_C;
            default: state_next = crsd_pkg::ST_IDLE;
        endcase
    end

    // ---------------- datapath, counters and memory controls ----------------
    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        rv_next   = rv_reg;     st_next   = st_reg;
        mask_next = mask_reg;   rdok_next = rdok_reg;
        u_next    = u_reg;      cnt_next  = cnt_reg;
        r_next    = r_reg;      j_next    = j_reg;
        col_next  = col_reg;    piv_next  = piv_reg;
        e_next    = e_reg;      t_next    = t_reg;
        usel_next = usel_reg;   src_next  = src_reg;
        f_next    = f_reg;      ip_next   = ip_reg;   c_next = c_reg;
        tmpw_next = tmpw_reg;   tmpi_next = tmpi_reg; srcb_next = srcb_reg;

        f_we = 1'b0; f_waddr = faddr(7'(s_unit_index), 17'(s_byte_offset));
        f_wdata = s_byte_value; f_raddr = f_waddr;
        w_we = 1'b0; w_waddr = maddr(r7, j7); w_wdata = 8'd0; w_raddr = maddr(r7, j7);
        i_we = 1'b0; i_waddr = maddr(r7, j7); i_wdata = 8'd0; i_raddr = maddr(r7, j7);
        c_we = 1'b0; c_waddr = cnt_reg[UW-1:0]; c_wdata = u_reg[UW-1:0];
        c_raddr = r_reg[UW-1:0];
        inv_start = 1'b0;
        inv_x     = cc_x;

        case (state_reg)
            crsd_pkg::ST_IDLE: begin
                if (acc) begin
                    case (crsd_pkg::op_t'(s_operation))
                        crsd_pkg::OP_LOAD: begin
                            f_we = in_ok;
                            m_valid_next = 1'b1; rv_next = 8'd0; st_next = crsd_pkg::STS_OK;
                        end
                        crsd_pkg::OP_DECODE: begin
                            mask_next = s_present_mask;
                            u_next = '0; cnt_next = '0;
                            if (badcfg) begin
                                m_valid_next = 1'b1; rv_next = 8'd0;
                                st_next = crsd_pkg::STS_BADCFG;
                            end
                        end
                        crsd_pkg::OP_READ: rdok_next = in_ok;
                        default: begin
                            m_valid_next = 1'b1; rv_next = 8'd0; st_next = crsd_pkg::STS_OK;
                        end
                    endcase
                end
            end
            crsd_pkg::ST_RD: begin
                m_valid_next = 1'b1;
                rv_next = rdok_reg ? f_rdata : 8'd0;
                st_next = crsd_pkg::STS_OK;
            end
            crsd_pkg::ST_SEL: begin
                if (cnt_reg == kc || u_reg == totc) begin
                    r_next = '0; j_next = '0;
                    if (cnt_reg != kc) begin
                        m_valid_next = 1'b1; rv_next = 8'd0; st_next = crsd_pkg::STS_TOO_MANY;
                    end else if (!erased) begin
                        m_valid_next = 1'b1; rv_next = 8'd0; st_next = crsd_pkg::STS_NONE;
                    end
                end else begin
                    if (mask_reg[u_reg[UW-1:0]]) begin
                        c_we = 1'b1;
                        cnt_next = cnt_reg + CW'(1);
                    end
                    u_next = u_reg + CW'(1);
                end
            end
            crsd_pkg::ST_CC_GO: inv_start = 1'b1;
            crsd_pkg::ST_CC_WT: begin
                if (inv_done) begin
                    if (inv_res == 8'd0) begin
                        m_valid_next = 1'b1; rv_next = 8'd0; st_next = crsd_pkg::STS_SINGULAR;
                    end else if (j_last) begin
                        j_next = '0;
                        r_next = rm_last ? '0 : r_reg + CW'(1);
                    end else begin
                        j_next = j_reg + CW'(1);
                    end
                end
            end
            crsd_pkg::ST_BL_RD: ;
            crsd_pkg::ST_BL_U: begin
                usel_next = c_rdata;
                j_next = '0;
            end
            crsd_pkg::ST_BL_EL, crsd_pkg::ST_BL_WT: begin
                inv_x = bl_x;
                if (state_reg == crsd_pkg::ST_BL_EL && usel7 >= k7) begin
                    inv_start = 1'b1;
                end else if (state_reg == crsd_pkg::ST_BL_EL || inv_done) begin
                    w_we = 1'b1;
                    i_we = 1'b1;
                    i_wdata = (j_reg == r_reg) ? 8'd1 : 8'd0;
                    if (state_reg == crsd_pkg::ST_BL_WT) w_wdata = inv_res;
                    else w_wdata = (j7 == usel7) ? 8'd1 : 8'd0;
                    if (!j_last) j_next = j_reg + CW'(1);
                    else if (!r_last) r_next = r_reg + CW'(1);
                    else begin
                        col_next = '0; r_next = '0;
                    end
                end
            end
            crsd_pkg::ST_PV_RD: w_raddr = maddr(r7, col7);
            crsd_pkg::ST_PV_CK: begin
                if (w_rdata != 8'd0) begin
                    piv_next = r_reg;
                    j_next = '0;
                end else if (r_last) begin
                    m_valid_next = 1'b1; rv_next = 8'd0; st_next = crsd_pkg::STS_SINGULAR;
                end else begin
                    r_next = r_reg + CW'(1);
                end
            end
            crsd_pkg::ST_SW_A: begin
                w_raddr = maddr(piv7, j7); i_raddr = maddr(piv7, j7);
            end
            crsd_pkg::ST_SW_B: begin
                tmpw_next = w_rdata; tmpi_next = i_rdata;
                w_raddr = maddr(col7, j7); i_raddr = maddr(col7, j7);
            end
            crsd_pkg::ST_SW_C: begin
                w_we = 1'b1; w_waddr = maddr(piv7, j7); w_wdata = w_rdata;
                i_we = 1'b1; i_waddr = maddr(piv7, j7); i_wdata = i_rdata;
            end
            crsd_pkg::ST_SW_D: begin
                w_we = 1'b1; w_waddr = maddr(col7, j7); w_wdata = tmpw_reg;
                i_we = 1'b1; i_waddr = maddr(col7, j7); i_wdata = tmpi_reg;
                j_next = j_reg + CW'(1);
            end
            crsd_pkg::ST_NM_RD: w_raddr = maddr(col7, col7);
            crsd_pkg::ST_NM_GO: begin
                inv_start = 1'b1;
                inv_x = w_rdata;
            end
            crsd_pkg::ST_NM_WT: begin
                if (inv_done) begin
                    ip_next = inv_res;
                    j_next = '0;
                    if (inv_res == 8'd0) begin
                        m_valid_next = 1'b1; rv_next = 8'd0; st_next = crsd_pkg::STS_SINGULAR;
                    end
                end
            end
            crsd_pkg::ST_NM_A: begin
                w_raddr = maddr(col7, j7); i_raddr = maddr(col7, j7);
            end
            crsd_pkg::ST_NM_B: begin
                w_we = 1'b1; w_waddr = maddr(col7, j7);
                w_wdata = crsd_pkg::gf_mul(w_rdata, ip_reg, poly_reg);
                i_we = 1'b1; i_waddr = maddr(col7, j7);
                i_wdata = crsd_pkg::gf_mul(i_rdata, ip_reg, poly_reg);
                j_next = j_reg + CW'(1);
                r_next = '0;
            end
            crsd_pkg::ST_EL_RD, crsd_pkg::ST_EL_CK, crsd_pkg::ST_EL_C: begin
                w_raddr = maddr(r7, col7);
                if (state_reg == crsd_pkg::ST_EL_CK) f_next = w_rdata;
                if (state_reg == crsd_pkg::ST_EL_C) begin
                    // row r minus f times the pivot row
                    w_we = 1'b1;
                    w_wdata = w_rdata ^ crsd_pkg::gf_mul(f_reg, tmpw_reg, poly_reg);
                    i_we = 1'b1;
                    i_wdata = i_rdata ^ crsd_pkg::gf_mul(f_reg, tmpi_reg, poly_reg);
                end
                if (state_reg == crsd_pkg::ST_EL_RD && r_reg != col_reg) begin
                    // issue the factor read
                end else if (state_reg == crsd_pkg::ST_EL_CK && w_rdata != 8'd0) begin
                    j_next = '0;
                end else if (state_reg == crsd_pkg::ST_EL_C && !j_last) begin
                    j_next = j_reg + CW'(1);
                end else if (!r_last) begin
                    r_next = r_reg + CW'(1);
                end else begin
                    col_next = col_reg + CW'(1);
                    r_next   = col_reg + CW'(1);
                    e_next   = '0;
                end
            end
            crsd_pkg::ST_EL_A: begin
                w_raddr = maddr(col7, j7); i_raddr = maddr(col7, j7);
            end
            crsd_pkg::ST_EL_B: begin
                tmpw_next = w_rdata; tmpi_next = i_rdata;
            end
            crsd_pkg::ST_RB_E: begin
                t_next = '0;
                r_next = '0;
                if (e_reg == kc) begin
                    m_valid_next = 1'b1; rv_next = 8'd0; st_next = crsd_pkg::STS_OK;
                end else if (mask_reg[e_reg[UW-1:0]]) begin
                    e_next = e_reg + CW'(1);
                end
            end
            crsd_pkg::ST_RB_CLR: begin
                f_we = 1'b1; f_waddr = faddr(e7, 17'(t_reg)); f_wdata = 8'd0;
                t_next = t_reg + 12'd1;
            end
            crsd_pkg::ST_RB_CRD: i_raddr = maddr(e7, r7);
            crsd_pkg::ST_RB_CCK, crsd_pkg::ST_RB_C: begin
                f_waddr = faddr(e7, 17'(t_reg));
                f_wdata = f_rdata ^ crsd_pkg::gf_mul(c_reg, srcb_reg, poly_reg);
                f_we = (state_reg == crsd_pkg::ST_RB_C);
                if (state_reg == crsd_pkg::ST_RB_CCK) begin
                    c_next = i_rdata; src_next = c_rdata;
                end
                if (state_reg == crsd_pkg::ST_RB_CCK && i_rdata != 8'd0) begin
                    t_next = '0;
                end else if (state_reg == crsd_pkg::ST_RB_C && !t_last) begin
                    t_next = t_reg + 12'd1;
                end else if (!r_last) begin
                    r_next = r_reg + CW'(1);
                end else begin
                    e_next = e_reg + CW'(1);
                end
            end
            crsd_pkg::ST_RB_A: f_raddr = faddr(src7, 17'(t_reg));
            crsd_pkg::ST_RB_B: begin
                srcb_next = f_rdata;
                f_raddr = faddr(e7, 17'(t_reg));
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= crsd_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        rv_reg   <= rv_next;   st_reg   <= st_next;
        mask_reg <= mask_next; rdok_reg <= rdok_next;
        u_reg    <= u_next;    cnt_reg  <= cnt_next;
        r_reg    <= r_next;    j_reg    <= j_next;
        col_reg  <= col_next;  piv_reg  <= piv_next;
        e_reg    <= e_next;    t_reg    <= t_next;
        usel_reg <= usel_next; src_reg  <= src_next;
        f_reg    <= f_next;    ip_reg   <= ip_next;   c_reg <= c_next;
        tmpw_reg <= tmpw_next; tmpi_reg <= tmpi_next; srcb_reg <= srcb_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_read_value = rv_reg;
    assign m_status     = st_reg;

    // ---------------- memories and inverse unit ----------------
    crsd_ram #(.WIDTH(8), .DEPTH(2 ** FAW)) u_frame (
        .aclk(aclk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
        .raddr(f_raddr), .rdata(f_rdata));

    crsd_ram #(.WIDTH(8), .DEPTH(2 ** MAW)) u_work (
        .aclk(aclk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
        .raddr(w_raddr), .rdata(w_rdata));

    crsd_ram #(.WIDTH(8), .DEPTH(2 ** MAW)) u_inverse (
        .aclk(aclk), .we(i_we), .waddr(i_waddr), .wdata(i_wdata),
        .raddr(i_raddr), .rdata(i_rdata));

    crsd_ram #(.WIDTH(UW), .DEPTH(2 ** UW)) u_chosen (
        .aclk(aclk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
        .raddr(c_raddr), .rdata(c_rdata));

    crsd_gf_inv u_inv (
        .aclk(aclk), .aresetn(aresetn), .start(inv_start), .x(inv_x),
        .poly(poly_reg), .done(inv_done), .inv(inv_res));

    // ---------------- assertions ----------------
    // result register is empty whenever an operation is in flight
    a_out_empty_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != crsd_pkg::ST_IDLE) |-> !m_valid_reg)
        else $error("result pending while busy");

    // after the read state the result register is always full and the block idle
    a_read_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == crsd_pkg::ST_RD) |=> (m_valid_reg && state_reg == crsd_pkg::ST_IDLE))
        else $error("read result missing");

    // inverse results only arrive in a waiting state
    a_inv_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        inv_done |-> (state_reg == crsd_pkg::ST_CC_WT || state_reg == crsd_pkg::ST_BL_WT ||
                      state_reg == crsd_pkg::ST_NM_WT))
        else $error("stray inverse result");

    // frame store is only written by loads and by the rebuild
    a_frame_write: assert property (@(posedge aclk) disable iff (!aresetn)
        f_we |-> (state_reg == crsd_pkg::ST_IDLE || state_reg == crsd_pkg::ST_RB_CLR ||
                  state_reg == crsd_pkg::ST_RB_C))
        else $error("unexpected frame write");
endmodule

[test/cauchy_rs_erasure_decoder_unit_chk.sv]
// Scoreboard for the Cauchy RS erasure decoder: watches the word channels and the
// register port, predicts each result from its own frame copy. Depends on crsd_pkg.
`timescale 1ns / 100ps

module cauchy_rs_erasure_decoder_unit_chk
    import crsd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [5:0]  s_unit_index,
    input  logic [10:0] s_byte_offset,
    input  logic [7:0]  s_byte_value,
    input  logic [63:0] s_present_mask,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [7:0]  m_read_value,
    input  logic [2:0]  m_status,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output int          mismatches,
    output int          outstanding,
    output int          n_results,
    output int          n_rebuilt,
    output int          n_singular
);

    typedef struct {
        logic [7:0] rd_byte;
        status_t    sts;
    } result_t;

    result_t    pending_results[$];

    logic [7:0] frame_copy [0:131071];
    logic [7:0] elim_mat [0:4095];
    logic [7:0] inv_mat [0:4095];
    logic [7:0] cauchy_rows [0:4095];
    logic [7:0] field_inv [0:255];
    logic [8:0] inv_poly_cache;

    logic [5:0]  k_units;
    logic [5:0]  m_units;
    logic [11:0] unit_len;
    logic [7:0]  poly;

    initial begin
        for (int i = 0; i < 131072; i++) frame_copy[i] = 8'd0;
        inv_poly_cache = 9'h100;
        mismatches = 0;
        n_results = 0;
        n_rebuilt = 0;
        n_singular = 0;
    end

    assign outstanding = pending_results.size();

    function automatic logic [7:0] gf_product(logic [7:0] a, logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] sh;
        logic       hi;
        acc = 8'd0;
        sh = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) acc = acc ^ sh;
            hi = sh[7];
            sh = {sh[6:0], 1'b0};
            if (hi) sh = sh ^ poly;
        end
        return acc;
    endfunction

    // inverse table only changes with the polynomial; 0 means no inverse
    function automatic void refresh_inverses();
        if (inv_poly_cache != {1'b0, poly}) begin
            for (int a = 0; a < 256; a++) begin
                field_inv[a] = 8'd0;
                for (int b = 0; b < 256; b++)
                    if (field_inv[a] == 8'd0 && gf_product(a[7:0], b[7:0]) == 8'd1)
                        field_inv[a] = b[7:0];
            end
            inv_poly_cache = {1'b0, poly};
        end
    endfunction

    function automatic status_t decode_frame(logic [63:0] mask);
        int         k, m, total, cnt, piv;
        int         chosen [64];
        logic       erased;
        logic [7:0] v, ip, f, acc, t8;
        k = k_units;
        m = m_units;
        total = k + m;
        if (k == 0 || m == 0 || total > 64 || unit_len == 0 || unit_len > 2048)
            return STS_BADCFG;
        cnt = 0;
        for (int u = 0; u < total && cnt < k; u++)
            if (mask[u]) begin
                chosen[cnt] = u;
                cnt++;
            end
        if (cnt < k) return STS_TOO_MANY;
        erased = 1'b0;
        for (int e = 0; e < k; e++)
            if (!mask[e]) erased = 1'b1;
        if (!erased) return STS_NONE;

        refresh_inverses();
        for (int r = 0; r < m; r++)
            for (int j = 0; j < k; j++) begin
                v = field_inv[(r ^ (m + j)) & 255];
                if (v == 8'd0) return STS_SINGULAR;
                cauchy_rows[r*k + j] = v;
            end

        for (int i = 0; i < k*k; i++) begin
            elim_mat[i] = 8'd0;
            inv_mat[i] = 8'd0;
        end
        for (int r = 0; r < k; r++) begin
            inv_mat[r*k + r] = 8'd1;
            if (chosen[r] < k) elim_mat[r*k + chosen[r]] = 8'd1;
            else
                for (int j = 0; j < k; j++)
                    elim_mat[r*k + j] = cauchy_rows[(chosen[r]-k)*k + j];
        end

        // Gauss-Jordan with row swaps on the first nonzero pivot
        for (int col = 0; col < k; col++) begin
            piv = k;
            for (int r = k - 1; r >= col; r--)
                if (elim_mat[r*k + col] != 8'd0) piv = r;
            if (piv == k) return STS_SINGULAR;
            if (piv != col)
                for (int j = 0; j < k; j++) begin
                    t8 = elim_mat[piv*k + j];
                    elim_mat[piv*k + j] = elim_mat[col*k + j];
                    elim_mat[col*k + j] = t8;
                    t8 = inv_mat[piv*k + j];
                    inv_mat[piv*k + j] = inv_mat[col*k + j];
                    inv_mat[col*k + j] = t8;
                end
            ip = field_inv[elim_mat[col*k + col]];
            if (ip == 8'd0) return STS_SINGULAR;
            for (int j = 0; j < k; j++) begin
                elim_mat[col*k + j] = gf_product(elim_mat[col*k + j], ip);
                inv_mat[col*k + j] = gf_product(inv_mat[col*k + j], ip);
            end
            for (int r = 0; r < k; r++) begin
                f = elim_mat[r*k + col];
                if (r != col && f != 8'd0)
                    for (int j = 0; j < k; j++) begin
                        elim_mat[r*k + j] ^= gf_product(f, elim_mat[col*k + j]);
                        inv_mat[r*k + j] ^= gf_product(f, inv_mat[col*k + j]);
                    end
            end
        end

        // survivors are never erased units, so each byte can be formed at once
        for (int e = 0; e < k; e++)
            if (!mask[e])
                for (int t = 0; t < unit_len; t++) begin
                    acc = 8'd0;
                    for (int r = 0; r < k; r++)
                        if (inv_mat[e*k + r] != 8'd0)
                            acc ^= gf_product(inv_mat[e*k + r],
                                              frame_copy[chosen[r]*2048 + t]);
                    frame_copy[e*2048 + t] = acc;
                end
        return STS_OK;
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t mismatch: %s got %0h want %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        result_t next_res;
        result_t head;
        if (!aresetn) begin
            k_units <= 6'd4;
            m_units <= 6'd2;
            unit_len <= 12'd1024;
            poly <= 8'd29;
        end else begin
            if (psel && penable && pwrite && pready)
                case (reg_idx_t'(paddr[3:2]))
                    REG_SOURCE_UNITS: k_units <= pwdata[5:0];
                    REG_PARITY_UNITS: m_units <= pwdata[5:0];
                    REG_UNIT_BYTES:   unit_len <= pwdata[11:0];
                    REG_FIELD_POLY:   poly <= pwdata[7:0];
                    default: ;
                endcase
            if (s_valid && s_ready) begin
                next_res.rd_byte = 8'd0;
                next_res.sts = STS_OK;
                case (op_t'(s_operation))
                    OP_LOAD:   frame_copy[{s_unit_index, s_byte_offset}] = s_byte_value;
                    OP_DECODE: next_res.sts = decode_frame(s_present_mask);
                    OP_READ:   next_res.rd_byte = frame_copy[{s_unit_index, s_byte_offset}];
                    default: ;
                endcase
                if (next_res.sts == STS_OK && op_t'(s_operation) == OP_DECODE) n_rebuilt++;
                if (next_res.sts == STS_SINGULAR) n_singular++;
                pending_results.push_back(next_res);
            end
            if (m_valid && m_ready) begin
                n_results++;
                if (pending_results.size() == 0) begin
                    report("result word with nothing pending", {m_read_value, m_status}, 0);
                end else begin
                    head = pending_results.pop_front();
                    if (m_read_value !== head.rd_byte)
                        report("read_value", m_read_value, head.rd_byte);
                    if (m_status !== head.sts)
                        report("status", m_status, head.sts);
                end
            end
        end
    end

endmodule

[test/cauchy_rs_erasure_decoder_unit_tb.sv]
// Regression bench for the Cauchy RS erasure decoder: drives words and register
// settings, random idling on both sides. Depends on crsd_pkg, the decoder and the checker module.
`timescale 1ns / 100ps

module cauchy_rs_erasure_decoder_unit_tb;
    import crsd_pkg::*;

    localparam int IDLE_LIMIT = 400000;   // cycles with no handshake at all

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_operation;
    logic [5:0]  s_unit_index;
    logic [10:0] s_byte_offset;
    logic [7:0]  s_byte_value;
    logic [63:0] s_present_mask;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_read_value;
    logic [2:0]  m_status;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int mismatches, outstanding, n_results, n_rebuilt, n_singular;

    // host-side view of which frame bytes hold data, so no read touches a
    // byte that was never written
    bit stored [0:131071];
    int stored_addrs [$];

    int words_sent;
    int rx_words;
    int idle_cycles;
    int settings_run;
    bit tx_burst;
    bit rx_burst;
    bit hold_done;

    // current settings as the host sees them
    int k_cur, m_cur, len_cur;

    cauchy_rs_erasure_decoder_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_operation(s_operation),
        .s_unit_index(s_unit_index), .s_byte_offset(s_byte_offset),
        .s_byte_value(s_byte_value), .s_present_mask(s_present_mask),
        .m_valid(m_valid), .m_ready(m_ready), .m_read_value(m_read_value),
        .m_status(m_status),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    cauchy_rs_erasure_decoder_unit_chk chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_operation(s_operation),
        .s_unit_index(s_unit_index), .s_byte_offset(s_byte_offset),
        .s_byte_value(s_byte_value), .s_present_mask(s_present_mask),
        .m_valid(m_valid), .m_ready(m_ready), .m_read_value(m_read_value),
        .m_status(m_status),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata),
        .mismatches(mismatches), .outstanding(outstanding), .n_results(n_results),
        .n_rebuilt(n_rebuilt), .n_singular(n_singular)
    );

    // 4 ns clock
    initial aclk = 1'b0;
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Watchdog: the limit sits well above the slowest decode used here.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || psel) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == IDLE_LIMIT) begin
                $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
                $display("cauchy_rs_erasure_decoder_unit regression: fail");
                $finish;
            end
        end
    end

    // Result side: random stalls, bursts with none, and one long hold-off so
    // the output register fills and s_ready drops while words keep coming.
    initial begin
        int gap;
        m_ready = 1'b0;
        rx_words = 0;
        rx_burst = 1'b0;
        hold_done = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (!hold_done && rx_words >= 200) begin
                hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (300) @(posedge aclk);
            end
            if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
            gap = rx_burst ? 0 : $urandom_range(0, 19);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            rx_words++;
        end
    end

    // One word; valid is only lowered when a gap follows, so it never gets
    // two assignments in one step.
    task automatic push_word(op_t op, logic [5:0] unit, logic [10:0] offs,
                             logic [7:0] val, logic [63:0] mask);
        int gap;
        if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_operation <= op;
        s_unit_index <= unit;
        s_byte_offset <= offs;
        s_byte_value <= val;
        s_present_mask <= mask;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        words_sent++;
        if (op == OP_LOAD && !stored[{unit, offs}]) begin
            stored[{unit, offs}] = 1'b1;
            stored_addrs.push_back({unit, offs});
        end
    endtask

    task automatic reg_write(reg_idx_t idx, logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Settings change only with nothing in flight: drain, settle, then write.
    task automatic apply_settings(int k, int m, int len, int fpoly);
        s_valid <= 1'b0;
        wait (outstanding == 0);
        repeat (10) @(posedge aclk);
        reg_write(REG_SOURCE_UNITS, k);
        reg_write(REG_PARITY_UNITS, m);
        reg_write(REG_UNIT_BYTES, len);
        reg_write(REG_FIELD_POLY, fpoly);
        k_cur = k;
        m_cur = m;
        len_cur = len;
        settings_run++;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Survivor mask. With the frame written, mostly a full frame with up to m
    // erasures; otherwise only masks that stop before touching frame data
    // (nothing erased, or too few survivors).
    function automatic logic [63:0] survivor_mask(bit frame_ready);
        int         total;
        logic [63:0] mask;
        total = (k_cur + m_cur > 64) ? 64 : k_cur + m_cur;
        if (frame_ready) begin
            if ($urandom_range(0, 3) == 0) return rand64();
            mask = (total == 64) ? '1 : ((64'd1 << total) - 64'd1);
            repeat ($urandom_range(1, m_cur)) mask[$urandom_range(0, total - 1)] = 1'b0;
        end else if ($urandom_range(0, 1) == 0) begin
            mask = (total == 64) ? '1 : ((64'd1 << total) - 64'd1);
            for (int u = k_cur; u < total; u++) mask[u] = $urandom_range(0, 1);
        end else begin
            mask = '0;
            repeat (k_cur - 1) mask[$urandom_range(0, total - 1)] = 1'b1;
        end
        // bits past the frame are ignored by the block
        if (total < 64) mask = mask | (rand64() << total);
        return mask;
    endfunction

    task automatic fill_frame();
        for (int u = 0; u < k_cur + m_cur; u++)
            for (int t = 0; t < len_cur; t++)
                push_word(OP_LOAD, u, t, $urandom_range(0, 255), rand64());
    endtask

    task automatic random_words(int count, bit frame_ready);
        int         pick;
        int         addr;
        logic [5:0] unit;
        logic [10:0] offs;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45 || (pick < 75 && stored_addrs.size() == 0)) begin
                if ($urandom_range(0, 1) == 0) begin
                    unit = $urandom_range(0, 63);
                    offs = $urandom_range(0, 2047);
                end else begin
                    unit = $urandom_range(0, k_cur + m_cur - 1 > 63 ? 63 : k_cur + m_cur - 1);
                    offs = $urandom_range(0, len_cur > 0 && len_cur <= 2048 ? len_cur - 1 : 0);
                end
                push_word(OP_LOAD, unit, offs, $urandom_range(0, 255), rand64());
            end else if (pick < 75) begin
                addr = stored_addrs[$urandom_range(0, stored_addrs.size() - 1)];
                push_word(OP_READ, addr[16:11], addr[10:0], $urandom_range(0, 255), rand64());
            end else if (pick < 93) begin
                push_word(OP_DECODE, $urandom_range(0, 63), $urandom_range(0, 2047),
                          $urandom_range(0, 255), survivor_mask(frame_ready));
            end else begin
                push_word(OP_NONE, $urandom_range(0, 63), $urandom_range(0, 2047),
                          $urandom_range(0, 255), rand64());
            end
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_operation = OP_LOAD;
        s_unit_index = '0;
        s_byte_offset = '0;
        s_byte_value = '0;
        s_present_mask = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        words_sent = 0;
        settings_run = 1;
        tx_burst = 1'b0;
        k_cur = 4;
        m_cur = 2;
        len_cur = 1024;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed, reset settings: address extremes, every operation, the
        // early-exit decode outcomes (nothing erased, too many erasures).
        push_word(OP_LOAD, 6'd63, 11'd2047, 8'hFF, '1);
        push_word(OP_LOAD, 6'd0, 11'd0, 8'h00, '0);
        push_word(OP_LOAD, 6'd0, 11'd1, 8'hA5, '0);
        push_word(OP_LOAD, 6'd63, 11'd2047, 8'h5A, '0);
        push_word(OP_READ, 6'd63, 11'd2047, 8'hFF, '1);
        push_word(OP_READ, 6'd0, 11'd0, 8'h00, '0);
        push_word(OP_READ, 6'd0, 11'd1, 8'h00, '0);
        push_word(OP_NONE, 6'd63, 11'd2047, 8'hFF, '1);
        push_word(OP_NONE, 6'd0, 11'd0, 8'h00, '0);
        push_word(OP_DECODE, 6'd0, 11'd0, 8'h00, '1);
        push_word(OP_DECODE, 6'd0, 11'd0, 8'h00, 64'h0);
        push_word(OP_DECODE, 6'd63, 11'd2047, 8'hFF, 64'hFFFF_FFFF_FFFF_FFF0);
        push_word(OP_DECODE, 6'd0, 11'd0, 8'h00, 64'h0000_0000_0000_000F);

        // small frame, default field: the bulk of the rebuilds
        apply_settings(4, 2, 16, 29);
        fill_frame();
        random_words(450, 1'b1);
        // largest unit length, early exits only
        apply_settings(2, 2, 2048, 29);
        random_words(80, 1'b0);
        // reducible polynomial: singular outcomes
        apply_settings(3, 3, 8, 255);
        fill_frame();
        random_words(150, 1'b1);
        // widest k with zero polynomial, early exits only
        apply_settings(63, 1, 1, 0);
        random_words(60, 1'b0);
        // bad configurations: k + m over the limit, zero length, oversize length
        apply_settings(63, 63, 16, 29);
        random_words(40, 1'b0);
        apply_settings(8, 4, 0, 29);
        random_words(40, 1'b0);
        apply_settings(5, 3, 4095, 29);
        random_words(40, 1'b0);
        // single source unit, widest parity
        apply_settings(1, 63, 4, 29);
        fill_frame();
        random_words(120, 1'b1);
        // another primitive polynomial
        apply_settings(6, 6, 12, 8'h2B);
        fill_frame();
        random_words(250, 1'b1);

        s_valid <= 1'b0;
        wait (outstanding == 0);
        repeat (20) @(posedge aclk);

        $display("covered %0d words over %0d register settings, %0d results checked",
                 words_sent, settings_run, n_results);
        $display("decodes rebuilt %0d frames, %0d ended singular; %0d mismatches",
                 n_rebuilt, n_singular, mismatches);
        if (mismatches == 0 && outstanding == 0) begin
            $display("cauchy_rs_erasure_decoder_unit regression: pass");
        end else begin
            $display("cauchy_rs_erasure_decoder_unit regression: fail");
        end
        $finish;
    end

endmodule
